>>> rtl/core/fcfs_pkg.sv
package fcfs_pkg;

    localparam int MAX_PROCS_DEF = 16;

    // Wide enough for a process number at the largest supported capacity.
    localparam int NUM_W = 7;

    typedef struct packed {
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic        final_process;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  process_number;
        logic [15:0] arrival_out;
        logic [15:0] burst_out;
        logic [20:0] completion_time;
        logic [20:0] turnaround_time;
        logic [19:0] waiting_time;
        logic [23:0] total_turnaround;
        logic [23:0] total_waiting;
        logic        overflow;
        logic        last_result;
    } t_out_word;

    typedef struct packed {
        logic [15:0]      arr;
        logic [15:0]      bur;
        logic [NUM_W-1:0] num;
    } t_entry;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/core/fcfs_schedule_metrics_top.sv
// Loading: one word per cycle; each process drops into its sorted place in the cell row.
// The final word moves the control into the result state, from which the first result is registered.
// Results then leave at one per cycle while the output is taken.
// Input ready is low during the result run and returns in the cycle that shows the last result.
// Reset (synchronous, active low) clears the counters, flags and output valid; the store
// needs no clearing.
module fcfs_schedule_metrics_top #(
    parameter int MAX_PROCS = fcfs_pkg::MAX_PROCS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fcfs_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fcfs_pkg::t_out_word o_out_data
);

    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    fcfs_pkg::t_state r_state;
    fcfs_pkg::t_state n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_remain;
    logic [CNT_W-1:0] n_remain;
    logic             r_dropped;
    logic             n_dropped;
    logic             r_first;
    logic             n_first;

    logic             w_accept;
    logic             w_room;
    logic [CNT_W-1:0] w_total;
    logic             w_step;
    logic             w_free;
    fcfs_pkg::t_cell_ctrl w_ctrl;
    fcfs_pkg::t_entry     w_new;
    fcfs_pkg::t_entry     w_entry [MAX_PROCS];
    logic                 w_gt    [MAX_PROCS];

    assign w_accept = i_in_valid && o_in_ready;
    assign w_room   = r_count < CNT_W'(MAX_PROCS);
    assign w_total  = w_room ? (r_count + CNT_W'(1)) : r_count;

    assign w_new.arr = i_in_data.arrival_time;
    assign w_new.bur = i_in_data.burst_time;
    assign w_new.num = fcfs_pkg::NUM_W'(r_count) + fcfs_pkg::NUM_W'(1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_remain  = r_remain;
        n_dropped = r_dropped;
        n_first   = r_first;
        case (r_state)
            fcfs_pkg::ST_LOAD: begin
                if (w_accept) begin
                    n_count   = w_total;
                    n_dropped = r_dropped || !w_room;
                    if (i_in_data.final_process) begin
                        n_count = '0;
                        n_first = 1'b1;
                        if (w_total == '0) begin
                            n_dropped = 1'b0;
                        end else begin
                            n_remain = w_total;
                            n_state  = fcfs_pkg::ST_EMIT;
                        end
                    end
                end
            end
            fcfs_pkg::ST_EMIT: begin
                if (w_step) begin
                    n_remain = r_remain - CNT_W'(1);
                    n_first  = 1'b0;
                    if (r_remain == CNT_W'(1)) begin
                        n_dropped = 1'b0;
                        n_state   = fcfs_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = fcfs_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        w_step       = 1'b0;
        w_ctrl.load  = 1'b0;
        w_ctrl.shift = 1'b0;
        case (r_state)
            fcfs_pkg::ST_LOAD: begin
                o_in_ready  = 1'b1;
                w_ctrl.load = i_in_valid && w_room;
            end
            fcfs_pkg::ST_EMIT: begin
                w_step       = w_free;
                w_ctrl.shift = w_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fcfs_pkg::ST_LOAD;
            r_count   <= '0;
            r_remain  <= '0;
            r_dropped <= 1'b0;
            r_first   <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_remain  <= n_remain;
            r_dropped <= n_dropped;
            r_first   <= n_first;
        end
    end

    // The row stays sorted by arrival; cell zero always holds the next process to report.
    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        fcfs_pkg::t_entry w_left;
        fcfs_pkg::t_entry w_right;
        logic             w_left_gt;

        if (g == 0) begin : g_head
            assign w_left    = w_new;
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == MAX_PROCS - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        fcfs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_new      (w_new),
            .i_occupied (r_count > CNT_W'(g)),
            .i_left_gt  (w_left_gt),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_gt       (w_gt[g]),
            .o_entry    (w_entry[g])
        );
    end

    fcfs_calc #(
        .MAX_PROCS (MAX_PROCS)
    ) u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_first     (r_first),
        .i_last      (r_remain == CNT_W'(1)),
        .i_ovf       (r_dropped),
        .i_entry     (w_entry[0]),
        .i_out_ready (i_out_ready),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PROCS))
        else $error("process count above capacity");

    a_emit_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcfs_pkg::ST_EMIT) |-> (r_remain != '0) && (r_count == '0))
        else $error("result run without pending results");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.final_process && (w_total != '0))
        |=> (r_state == fcfs_pkg::ST_EMIT) && r_first)
        else $error("final word did not start a result run");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_remain == CNT_W'(1)))
        |=> (r_state == fcfs_pkg::ST_LOAD) && !r_dropped && o_out_valid)
        else $error("result run did not close cleanly");
`endif

endmodule

>>> rtl/core/fcfs_cell.sv
module fcfs_cell (
    input  logic               i_clk,
    input  fcfs_pkg::t_cell_ctrl i_ctrl,
    input  fcfs_pkg::t_entry   i_new,
    input  logic               i_occupied,
    input  logic               i_left_gt,
    input  fcfs_pkg::t_entry   i_left,
    input  fcfs_pkg::t_entry   i_right,
    output logic               o_gt,
    output fcfs_pkg::t_entry   o_entry
);

    fcfs_pkg::t_entry r_entry;
    fcfs_pkg::t_entry n_entry;

    // A strict compare keeps equal arrivals in load order.
    assign o_gt    = !i_occupied || (r_entry.arr > i_new.arr);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift) begin
            n_entry = i_right;
        end else if (i_ctrl.load && o_gt) begin
            n_entry = i_left_gt ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> rtl/core/fcfs_calc.sv
module fcfs_calc #(
    parameter int MAX_PROCS = fcfs_pkg::MAX_PROCS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_first,
    input  logic                i_last,
    input  logic                i_ovf,
    input  fcfs_pkg::t_entry    i_entry,
    input  logic                i_out_ready,
    output logic                o_free,
    output logic                o_out_valid,
    output fcfs_pkg::t_out_word o_out_data
);

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int CT_W  = 16 + CNT_W;
    localparam int TOT_W = CT_W + CNT_W;

    logic [CT_W-1:0]  r_prev_ct;
    logic [TOT_W-1:0] r_tot_tt;
    logic [TOT_W-1:0] r_tot_wt;
    logic             r_valid;
    fcfs_pkg::t_out_word r_data;

    logic [CT_W-1:0]  w_arr;
    logic [CT_W-1:0]  w_start;
    logic [CT_W-1:0]  w_ct;
    logic [CT_W-1:0]  w_wt;
    logic [CT_W-1:0]  w_tt;
    logic [TOT_W-1:0] w_tot_tt;
    logic [TOT_W-1:0] w_tot_wt;
    logic [31:0]      w_ct32;
    logic [31:0]      w_tt32;
    logic [31:0]      w_wt32;
    logic [31:0]      w_ttt32;
    logic [31:0]      w_twt32;
    fcfs_pkg::t_out_word w_word;

    // Service starts at the later of arrival and the previous completion.
    always_comb begin
        w_arr    = CT_W'(i_entry.arr);
        w_start  = (i_first || (w_arr > r_prev_ct)) ? w_arr : r_prev_ct;
        w_ct     = w_start + CT_W'(i_entry.bur);
        w_wt     = w_start - w_arr;
        w_tt     = w_ct - w_arr;
        w_tot_tt = (i_first ? '0 : r_tot_tt) + TOT_W'(w_tt);
        w_tot_wt = (i_first ? '0 : r_tot_wt) + TOT_W'(w_wt);
        w_ct32   = 32'(w_ct);
        w_tt32   = 32'(w_tt);
        w_wt32   = 32'(w_wt);
        w_ttt32  = 32'(w_tot_tt);
        w_twt32  = 32'(w_tot_wt);

        w_word.process_number   = i_entry.num[4:0];
        w_word.arrival_out      = i_entry.arr;
        w_word.burst_out        = i_entry.bur;
        w_word.completion_time  = (w_ct32 > 32'h1F_FFFF) ? '1 : w_ct32[20:0];
        w_word.turnaround_time  = (w_tt32 > 32'h1F_FFFF) ? '1 : w_tt32[20:0];
        w_word.waiting_time     = (w_wt32 > 32'h0F_FFFF) ? '1 : w_wt32[19:0];
        w_word.total_turnaround = (w_ttt32 > 32'hFF_FFFF) ? '1 : w_ttt32[23:0];
        w_word.total_waiting    = (w_twt32 > 32'hFF_FFFF) ? '1 : w_twt32[23:0];
        w_word.overflow         = i_ovf;
        w_word.last_result      = i_last;
    end

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_data    <= w_word;
            r_prev_ct <= w_ct;
            r_tot_tt  <= w_tot_tt;
            r_tot_wt  <= w_tot_wt;
        end
    end

endmodule
